// File: rtl/core/olpd_pkg.sv
// ----------------------------------------------------------------------------
// olpd_pkg
// shared types and constants for the ordered list with positional delete
// ----------------------------------------------------------------------------
package olpd_pkg;

  // default list capacity
  localparam int unsigned LIST_DEPTH = 16;

  // width of one stored entry
  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_DEL_FRONT = 2'd1,
    CMD_DEL_POS   = 2'd2,
    CMD_DEL_END   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE  = 3'd0,
    FSM_READ  = 3'd1,
    FSM_SH_RD = 3'd2,
    FSM_SH_WR = 3'd3,
    FSM_RESP  = 3'd4
  } fsm_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [31:0] value;
    logic [7:0]         position;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed_value;
    logic [4:0]         entry_count;
  } out_word_t;

endpackage

// File: rtl/core/olpd_ram.sv
// ----------------------------------------------------------------------------
// olpd_ram
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module olpd_ram #(
  parameter int unsigned Depth = olpd_pkg::LIST_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [olpd_pkg::WORD_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [olpd_pkg::WORD_W-1:0] rdata_o
);

  logic [olpd_pkg::WORD_W-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/core/olpd_ctrl.sv
// ----------------------------------------------------------------------------
// olpd_ctrl
// command sequencer: head pointer and count of a circular buffer in the ram,
// gap closing after a delete that is neither at the front nor at the end
// ----------------------------------------------------------------------------
module olpd_ctrl #(
  parameter int unsigned ListDepth = olpd_pkg::LIST_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command side
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  olpd_pkg::in_word_t            in_word_i,
  // result side
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output olpd_pkg::out_word_t           res_word_o,
  // ram port
  output logic                          mem_we_o,
  output logic [$clog2(ListDepth)-1:0]  mem_waddr_o,
  output logic [olpd_pkg::WORD_W-1:0]   mem_wdata_o,
  output logic                          mem_re_o,
  output logic [$clog2(ListDepth)-1:0]  mem_raddr_o,
  input  logic [olpd_pkg::WORD_W-1:0]   mem_rdata_i
);

  localparam int unsigned IdxW = $clog2(ListDepth);
  localparam int unsigned CntW = $clog2(ListDepth + 1);
  localparam int unsigned ExtW = CntW + 5;

  function automatic logic [IdxW-1:0] ptr_inc(input logic [IdxW-1:0] p);
    ptr_inc = (p == IdxW'(ListDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] ptr_dec(input logic [IdxW-1:0] p);
    ptr_dec = (p == '0) ? IdxW'(ListDepth - 1) : p - 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] ptr_add(input logic [IdxW-1:0] a,
                                              input logic [IdxW-1:0] b);
    logic [IdxW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (IdxW + 1)'(ListDepth)) begin
      sum = sum - (IdxW + 1)'(ListDepth);
    end
    ptr_add = sum[IdxW-1:0];
  endfunction

  olpd_pkg::fsm_e      state_q, state_d;
  logic [IdxW-1:0]     head_q, head_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [IdxW-1:0]     cur_q, cur_d;
  logic [CntW-1:0]     left_q, left_d;
  logic                front_q, front_d;
  olpd_pkg::status_e   status_q, status_d;
  logic [olpd_pkg::WORD_W-1:0] removed_q, removed_d;

  logic                in_fire;
  logic                res_fire;
  olpd_pkg::status_e   dec_status;
  logic                dec_ins;
  logic                dec_del;
  logic [IdxW-1:0]     dec_idx;
  logic [ExtW-1:0]     cnt_ext;

  assign in_ready_o = (state_q == olpd_pkg::FSM_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == olpd_pkg::FSM_RESP);
  assign res_fire   = res_valid_o && res_ready_i;

  // command decode against the current count
  always_comb begin
    dec_status = olpd_pkg::ST_OK;
    dec_ins    = 1'b0;
    dec_del    = 1'b0;
    dec_idx    = '0;
    if (in_word_i.command == olpd_pkg::CMD_INS_FRONT) begin
      if (cnt_q == CntW'(ListDepth)) begin
        dec_status = olpd_pkg::ST_FULL;
      end else begin
        dec_ins = 1'b1;
      end
    end else if (cnt_q == '0) begin
      dec_status = olpd_pkg::ST_EMPTY;
    end else begin
      unique case (in_word_i.command)
        olpd_pkg::CMD_DEL_FRONT: begin
          dec_del = 1'b1;
        end
        olpd_pkg::CMD_DEL_END: begin
          dec_del = 1'b1;
          dec_idx = IdxW'(cnt_q - 1'b1);
        end
        olpd_pkg::CMD_DEL_POS: begin
          if (in_word_i.position == '0 || in_word_i.position > 8'(cnt_q)) begin
            dec_status = olpd_pkg::ST_BADPOS;
          end else begin
            dec_del = 1'b1;
            dec_idx = IdxW'(in_word_i.position - 8'd1);
          end
        end
        default: begin
          dec_del = 1'b0;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      olpd_pkg::FSM_IDLE: begin
        if (in_fire) begin
          state_d = dec_del ? olpd_pkg::FSM_READ : olpd_pkg::FSM_RESP;
        end
      end
      olpd_pkg::FSM_READ: begin
        state_d = (left_q == '0) ? olpd_pkg::FSM_RESP : olpd_pkg::FSM_SH_RD;
      end
      olpd_pkg::FSM_SH_RD: begin
        state_d = olpd_pkg::FSM_SH_WR;
      end
      olpd_pkg::FSM_SH_WR: begin
        state_d = (left_q == CntW'(1)) ? olpd_pkg::FSM_RESP : olpd_pkg::FSM_SH_RD;
      end
      olpd_pkg::FSM_RESP: begin
        if (res_fire) begin
          state_d = olpd_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = olpd_pkg::FSM_IDLE;
      end
    endcase
  end

  // datapath and ram control
  always_comb begin
    head_d      = head_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    left_d      = left_q;
    front_d     = front_q;
    status_d    = status_q;
    removed_d   = removed_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_inc(cur_q);
    unique case (state_q)
      olpd_pkg::FSM_IDLE: begin
        if (in_fire) begin
          status_d  = dec_status;
          removed_d = '0;
          front_d   = (in_word_i.command == olpd_pkg::CMD_DEL_FRONT);
          if (dec_ins) begin
            head_d      = ptr_dec(head_q);
            cnt_d       = cnt_q + 1'b1;
            mem_we_o    = 1'b1;
            mem_waddr_o = ptr_dec(head_q);
            mem_wdata_o = in_word_i.value;
          end
          if (dec_del) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = ptr_add(head_q, dec_idx);
            cur_d       = ptr_add(head_q, dec_idx);
            // front deletes move the head, so nothing behind needs to shift
            left_d      = (in_word_i.command == olpd_pkg::CMD_DEL_FRONT) ? '0
                          : cnt_q - 1'b1 - CntW'(dec_idx);
          end
        end
      end
      olpd_pkg::FSM_READ: begin
        removed_d = mem_rdata_i;
        cnt_d     = cnt_q - 1'b1;
        if (front_q) begin
          head_d = ptr_inc(head_q);
        end
      end
      olpd_pkg::FSM_SH_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = ptr_inc(cur_q);
      end
      olpd_pkg::FSM_SH_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cur_q;
        mem_wdata_o = mem_rdata_i;
        cur_d       = ptr_inc(cur_q);
        left_d      = left_q - 1'b1;
      end
      olpd_pkg::FSM_RESP: begin
        mem_we_o = 1'b0;
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  assign cnt_ext                  = ExtW'(cnt_q);
  assign res_word_o.status        = status_q;
  assign res_word_o.removed_value = removed_q;
  assign res_word_o.entry_count   = cnt_ext[4:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olpd_pkg::FSM_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      front_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      front_q <= front_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ListDepth))
    else $error("entry count above capacity");

  a_ins_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && dec_ins) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("insert did not grow the count");

  a_write_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> ((state_q == olpd_pkg::FSM_SH_WR) || (in_fire && dec_ins)))
    else $error("ram written outside insert or shift");

  a_shift_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == olpd_pkg::FSM_SH_RD) || (state_q == olpd_pkg::FSM_SH_WR))
      |-> (left_q != '0))
    else $error("shift step with nothing left to move");

  a_refused_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !dec_ins && !dec_del) |=> ($stable(cnt_q) && $stable(head_q)))
    else $error("refused command changed the list");

endmodule

// File: rtl/core/ordered_list_positional_delete_core.sv
// ----------------------------------------------------------------------------
// ordered_list_positional_delete_core
// bounded ordered list of signed 32-bit values with insert at front and
// delete at front, at a 1-based position, or at the end
// ----------------------------------------------------------------------------
//  channel   direction  handshake               word
//  in        input      in_valid_i / in_ready_o  command, value, position
//  out       output     out_valid_o / out_ready_i status, removed_value, entry_count
//
//  insert and every refused command go from accept straight to the result
//  delete front and delete end add one ram read of the removed entry
//  delete at position p also moves the count - p entries behind the gap down,
//    one at a time through the single ram read and write port
//  reset empties the list at once; the entry ram itself is not cleared
//  a finished word waits in the output register while the next command is taken;
//    the sequencer stalls in its result state only when that register is full
// ----------------------------------------------------------------------------
module ordered_list_positional_delete_core #(
  parameter int unsigned ListDepth = olpd_pkg::LIST_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  olpd_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output olpd_pkg::out_word_t out_word_o
);

  localparam int unsigned IdxW = $clog2(ListDepth);

  // sequencer to ram
  logic                        mem_we;
  logic [IdxW-1:0]             mem_waddr;
  logic [olpd_pkg::WORD_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [IdxW-1:0]             mem_raddr;
  logic [olpd_pkg::WORD_W-1:0] mem_rdata;

  // sequencer to output register
  logic                res_valid;
  logic                res_ready;
  olpd_pkg::out_word_t res_word;

  // output register
  logic                out_valid_q, out_valid_d;
  olpd_pkg::out_word_t out_word_q;

  // command sequencer: owns head pointer and count
  olpd_ctrl #(
    .ListDepth (ListDepth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_word_o  (res_word),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // entry store, used as a circular buffer starting at the head
  olpd_ram #(
    .Depth (ListDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register takes a new word when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload holds unless a new word loads
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
